>>> rtl/smpq_pkg.sv
// Shared types and constants for the sorted minimum priority queue.
package smpq_pkg;

   localparam int DEPTH   = 16;
   localparam int DATA_W  = 32;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [COUNT_W-1:0]       count_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // Command broadcast to every cell in the chain
   typedef struct packed {
      logic     insert;
      logic     remove;
      data_type value;
   } cmd_type;

   // What a cell shows its upper neighbor
   typedef struct packed {
      data_type entry;
      logic     greater;
   } link_type;

endpackage

>>> rtl/smpq_cell.sv
// One slot of the sorted chain: holds an entry, compares it to the new value, shifts.
module smpq_cell (
   input  logic               clock,
   input  smpq_pkg::cmd_type  cmd,
   input  logic               in_use,
   input  smpq_pkg::link_type left,
   input  smpq_pkg::data_type right_entry,
   output smpq_pkg::link_type link
);
   import smpq_pkg::*;

   data_type entry_ff;
   data_type entry_in;

   // Flag when the new value belongs at or below this slot; empty slots act as +inf
   always_comb begin
      link.entry   = entry_ff;
      link.greater = !in_use || (cmd.value < entry_ff);
   end

   // Insert: take the lower neighbor's entry if it also moves up, else the value.
   // Remove: take the upper neighbor's entry.
   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert && link.greater) begin
         entry_in = left.greater ? left.entry : cmd.value;
      end else if (cmd.remove) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

>>> rtl/sorted_min_priority_queue_top.sv
// Top level of the sorted minimum priority queue: cell chain, count and result register.
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+------------------------------
//   request  | req_operation, req_value                | taken when start && !busy
//   response | rsp_status, rsp_min_value, rsp_count    | rsp_valid strobe, one cycle
//
// All cells compare against the new value and shift together, so a new item can be
// taken on every clock and its result shows on the following cycle. busy stays low.
// Synchronous reset empties the queue (count to zero) and clears the strobe; entry
// contents are left as they are. The receiver cannot stall, so nothing is ever held
// back.
module sorted_min_priority_queue_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_operation,
   input  smpq_pkg::data_type req_value,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output smpq_pkg::data_type rsp_min_value,
   output smpq_pkg::count_type rsp_count
);
   import smpq_pkg::*;

   count_type  count_ff;
   count_type  count_in;
   logic       rsp_valid_ff;
   status_type status_ff;
   status_type status_in;
   logic       accept;
   logic       full;
   logic       empty;
   cmd_type    cmd;
   link_type   links [DEPTH];

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = (count_ff == count_type'(DEPTH));
   assign empty  = (count_ff == '0);

   // Decode the operation into chain commands and the next count and status
   always_comb begin
      cmd.insert = 1'b0;
      cmd.remove = 1'b0;
      cmd.value  = req_value;
      count_in   = count_ff;
      status_in  = status_ff;
      if (accept) begin
         status_in = STATUS_DONE;
         if (req_operation == OP_INSERT) begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               cmd.insert = 1'b1;
               count_in   = count_ff + count_type'(1);
            end
         end else begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               cmd.remove = 1'b1;
               count_in   = count_ff - count_type'(1);
            end
         end
      end
   end

   // Build the chain; slot 0 holds the smallest entry
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      link_type left;
      data_type right_entry;
      logic     in_use;

      assign in_use = (count_type'(i) < count_ff);

      if (i == 0) begin : g_first
         assign left = '{entry: '0, greater: 1'b0};
      end else begin : g_inner
         assign left = links[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_body
         assign right_entry = links[i+1].entry;
      end

      smpq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .in_use      (in_use),
         .left        (left),
         .right_entry (right_entry),
         .link        (links[i])
      );
   end

   // Hold count and the result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         status_ff    <= STATUS_DONE;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
         status_ff    <= status_in;
      end
   end

   // Drive the result from the updated chain
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_min_value = empty ? data_type'(0) : links[0].entry;
   assign rsp_count     = count_ff;

endmodule

>>> rtl/smpq_checker.sv
// Port-level checks for the sorted minimum priority queue, bound to the top level.
module smpq_checker (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                req_operation,
   input smpq_pkg::data_type  req_value,
   input logic                rsp_valid,
   input logic [1:0]          rsp_status,
   input smpq_pkg::data_type  rsp_min_value,
   input smpq_pkg::count_type rsp_count
);
   import smpq_pkg::*;

   // Every accepted item gives a result on the next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid)
      else $error("accepted item produced no result");

   // No result without an item accepted the cycle before
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_valid)
      else $error("result without accepted item");

   // Empty queue reports zero as its minimum
   a_empty_min: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_count == '0) |-> rsp_min_value == '0)
      else $error("nonzero minimum on empty queue");

   // A dropped insert only happens at full depth
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_FULL) |-> rsp_count == count_type'(DEPTH))
      else $error("insert dropped below full depth");

   // A rejected remove only happens on an empty queue
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_EMPTY) |-> rsp_count == '0)
      else $error("remove rejected on nonempty queue");

endmodule

bind sorted_min_priority_queue_top smpq_checker u_smpq_checker (.*);

>>> test/sorted_min_priority_queue_checker.sv
// Checker for the sorted minimum priority queue: tracks the queue contents and compares results.
module sorted_min_priority_queue_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic                req_operation,
   input  smpq_pkg::data_type  req_value,
   input  logic                rsp_valid,
   input  logic [1:0]          rsp_status,
   input  smpq_pkg::data_type  rsp_min_value,
   input  smpq_pkg::count_type rsp_count,
   output int                  outstanding,
   output int                  fail_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import smpq_pkg::*;

   typedef struct {
      status_type status;
      data_type   min_value;
      count_type  count;
   } queue_snapshot_type;

   // Shadow copy of the queue, ascending, smallest at index zero
   data_type           shadow_values [DEPTH];
   int                 shadow_count = 0;
   queue_snapshot_type expected_snapshots [$];
   int                 mismatch_count = 0;

   assign fail_count = mismatch_count;

   // Apply one item to the shadow queue and return the result it should produce
   function automatic queue_snapshot_type apply_queue_op(op_type op, data_type value);
      queue_snapshot_type snap;
      int                 pos;
      snap.status = STATUS_DONE;
      if (op == OP_INSERT) begin
         if (shadow_count >= DEPTH) begin
            snap.status = STATUS_FULL;
         end else begin
            // shift strictly larger entries up; equal ones stay ahead of the new value
            pos = shadow_count;
            while (pos > 0 && value < shadow_values[pos-1]) begin
               shadow_values[pos] = shadow_values[pos-1];
               pos--;
            end
            shadow_values[pos] = value;
            shadow_count++;
         end
      end else if (shadow_count == 0) begin
         snap.status = STATUS_EMPTY;
      end else begin
         for (int i = 1; i < shadow_count; i++) begin
            shadow_values[i-1] = shadow_values[i];
         end
         shadow_count--;
      end
      snap.min_value = (shadow_count > 0) ? shadow_values[0] : '0;
      snap.count     = count_type'(shadow_count);
      return snap;
   endfunction

   always @(posedge clock) begin
      queue_snapshot_type want;
      if (reset) begin
         shadow_count = 0;
         expected_snapshots.delete();
      end else begin
         // match a result against the oldest pending item
         if (rsp_valid !== 1'b0) begin
            if (expected_snapshots.size() == 0) begin
               $error("result with no item pending: status %0d min_value %0d count %0d",
                      rsp_status, rsp_min_value, rsp_count);
               mismatch_count++;
            end else begin
               want = expected_snapshots.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  mismatch_count++;
               end
               if (rsp_min_value !== want.min_value) begin
                  $error("min_value: expected %0d, got %0d", want.min_value, rsp_min_value);
                  mismatch_count++;
               end
               if (rsp_count !== want.count) begin
                  $error("count: expected %0d, got %0d", want.count, rsp_count);
                  mismatch_count++;
               end
            end
         end
         // predict the result of an item taken at this edge
         if (start && !busy) begin
            expected_snapshots.push_back(apply_queue_op(op_type'(req_operation), req_value));
         end
      end
      outstanding <= expected_snapshots.size();
   end

endmodule

>>> test/testbench.sv
// Top of the priority queue testbench: clock, reset, item stimulus and the final verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import smpq_pkg::*;

   localparam int       RANDOM_ITEMS  = 800;
   localparam int       IDLE_PCT      = 29;
   localparam int       DRAIN_CYCLES  = 8;
   localparam int       CYCLE_LIMIT   = 20000;
   localparam data_type MAX_VALUE     = {1'b0, {(DATA_W-1){1'b1}}};
   localparam data_type MIN_VALUE     = {1'b1, {(DATA_W-1){1'b0}}};

   logic      clock;
   logic      reset;
   logic      start;
   logic      busy;
   logic      req_operation;
   data_type  req_value;
   logic      rsp_valid;
   logic [1:0] rsp_status;
   data_type  rsp_min_value;
   count_type rsp_count;
   int        outstanding;
   int        fail_count;
   int        cycle_count = 0;

   sorted_min_priority_queue_top uut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_min_value (rsp_min_value),
      .rsp_count     (rsp_count)
   );

   sorted_min_priority_queue_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_min_value (rsp_min_value),
      .rsp_count     (rsp_count),
      .outstanding   (outstanding),
      .fail_count    (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Present one item and hold it until the queue takes it
   task automatic send_item(input op_type op, input data_type value);
      req_operation <= op;
      req_value     <= value;
      start         <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Drop start for a random number of cycles, scrambling the idle payload
   task automatic idle_cycles(input int pct);
      while ($urandom_range(99) < pct) begin
         start         <= 1'b0;
         req_operation <= 1'($urandom);
         req_value     <= data_type'($urandom);
         @(posedge clock);
      end
   endtask

   initial begin
      int       insert_pct;
      int       idle_pct;
      data_type item_value;
      op_type   item_op;

      start         = 1'b0;
      req_operation = OP_INSERT;
      req_value     = '0;
      reset         = 1'b1;
      insert_pct    = 50;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: remove on empty, extremes with duplicates, fill, overflow, drain a few
      send_item(OP_REMOVE, MAX_VALUE);
      send_item(OP_INSERT, MAX_VALUE);
      send_item(OP_INSERT, MIN_VALUE);
      send_item(OP_INSERT, '0);
      send_item(OP_INSERT, -1);
      send_item(OP_INSERT, '0);
      send_item(OP_INSERT, MAX_VALUE);
      send_item(OP_INSERT, MIN_VALUE);
      repeat (DEPTH - 7) send_item(OP_INSERT, data_type'($urandom));
      send_item(OP_INSERT, 5);
      send_item(OP_INSERT, MIN_VALUE);
      repeat (4) send_item(OP_REMOVE, data_type'($urandom));

      // Random: insert mix shifts every 50 items so the queue swings between full and empty
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 50 == 0) begin
            case ($urandom_range(4))
               0: insert_pct = 10;
               1: insert_pct = 35;
               2: insert_pct = 50;
               3: insert_pct = 65;
               default: insert_pct = 90;
            endcase
         end
         // wait for every pending result before resuming
         if (n == 300 || n == 650) begin
            start <= 1'b0;
            @(posedge clock);
            while (outstanding != 0) @(posedge clock);
         end
         // mix full-range, clustered and extreme values to hit duplicates often
         case ($urandom_range(9))
            0, 1, 2, 3, 4: item_value = data_type'($urandom);
            5, 6, 7:       item_value = data_type'($urandom_range(16)) - 8;
            8:             item_value = $urandom_range(1) ? MAX_VALUE : MIN_VALUE;
            default:       item_value = $urandom_range(1) ? data_type'(0) : data_type'(-1);
         endcase
         item_op  = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
         idle_pct = (n >= 350 && n < 550) ? 0 : IDLE_PCT;
         idle_cycles(idle_pct);
         send_item(item_op, item_value);
      end

      // Drain and report
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/smpq_pkg.sv
rtl/smpq_cell.sv
rtl/sorted_min_priority_queue_top.sv
rtl/smpq_checker.sv
test/sorted_min_priority_queue_checker.sv
test/testbench.sv
